// ===== rtl/dfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_pkg: shared definitions for the delimiter frame receiver
// Store geometry, field widths, reset values, register indexes, states.
// ----------------------------------------------------------------------------
package dfr_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int OUT_DATA_W  = 16;

    localparam logic [BYTE_W-1:0] RESET_DELIMITER = 8'd35;
    localparam logic [CNT_W-1:0]  RESET_CAPACITY  = 7'd64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'b1;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;

    typedef enum logic [4:0] {
        ST_WAIT = 5'b00001,
        ST_RECV = 5'b00010,
        ST_READ = 5'b00100,
        ST_SHOW = 5'b01000,
        ST_ERR  = 5'b10000
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/delimiter_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delimiter_frame_receiver_unit: delimiter framed byte receiver
// Collects bytes between delimiters and replays each completed frame.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one received byte per beat. Delimiters outside a frame
//    are dropped; any other byte opens a frame and is stored.
//  - A delimiter closes the frame: m_axis replays the stored bytes in order,
//    tdata holding the byte and the frame length, tlast on the final beat.
//  - A byte beyond the capacity limit discards the frame and yields one
//    error beat (tuser = 1, payload and length zero, tlast = 1).
//  - Each stored byte is written as it is accepted. Each result beat is a RAM
//    read (READ), then presented (SHOW), paced by the single registered read port.
//  - s_axis_tready is low from frame close until the last result beat is
//    taken, and while an error beat waits; m_axis stalls just hold the beat.
//  - Reset (synchronous, active low) sets delimiter '#', capacity 64 and an
//    empty store; no clearing pass is needed.
//  - The configuration port writes delimiter (index 0) or capacity (index 1);
//    write only while the block is idle.
// ----------------------------------------------------------------------------
module delimiter_frame_receiver_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [dfr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dfr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [dfr_pkg::BYTE_W-1:0]        s_axis_tdata,   // [7:0] rx_byte
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [dfr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [7:0] payload,
                                                                   // [14:8] frame_length
    output logic                                   m_axis_tuser,   // [0] kind
    output logic                                   m_axis_tlast
);

    logic [dfr_pkg::BYTE_W-1:0] r_delimiter;
    logic [dfr_pkg::CNT_W-1:0]  r_capacity;

    logic                        wr_en;
    logic [dfr_pkg::ADDR_W-1:0]  wr_addr;
    logic [dfr_pkg::BYTE_W-1:0]  wr_data;
    logic                        rd_en;
    logic [dfr_pkg::ADDR_W-1:0]  rd_addr;
    logic [dfr_pkg::BYTE_W-1:0]  rd_data;
    logic [dfr_pkg::BYTE_W-1:0]  out_payload;
    logic [dfr_pkg::CNT_W-1:0]   out_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter <= dfr_pkg::RESET_DELIMITER;
            r_capacity  <= dfr_pkg::RESET_CAPACITY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dfr_pkg::REG_DELIMITER: r_delimiter <= i_cfg_wdata[dfr_pkg::BYTE_W-1:0];
                dfr_pkg::REG_CAPACITY:  r_capacity  <= i_cfg_wdata[dfr_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    dfr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_delimiter   (r_delimiter),
        .i_capacity    (r_capacity),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_in_byte     (s_axis_tdata),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_kind    (m_axis_tuser),
        .o_out_payload (out_payload),
        .o_out_length  (out_length),
        .o_out_last    (m_axis_tlast),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

    dfr_ram #(
        .WIDTH  (dfr_pkg::BYTE_W),
        .DEPTH  (dfr_pkg::STORE_DEPTH),
        .ADDR_W (dfr_pkg::ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign m_axis_tdata = {1'b0, out_length, out_payload};

endmodule
`default_nettype wire

// ===== rtl/dfr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_ram: generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dfr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/dfr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_ctrl: frame sequencer
// Fill counter with two limit compares, replay index, frame length register.
// ----------------------------------------------------------------------------
module dfr_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [dfr_pkg::BYTE_W-1:0]   i_delimiter,
    input  wire logic [dfr_pkg::CNT_W-1:0]    i_capacity,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [dfr_pkg::BYTE_W-1:0]   i_in_byte,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_out_kind,
    output logic      [dfr_pkg::BYTE_W-1:0]   o_out_payload,
    output logic      [dfr_pkg::CNT_W-1:0]    o_out_length,
    output logic                              o_out_last,
    output logic                              o_wr_en,
    output logic      [dfr_pkg::ADDR_W-1:0]   o_wr_addr,
    output logic      [dfr_pkg::BYTE_W-1:0]   o_wr_data,
    output logic                              o_rd_en,
    output logic      [dfr_pkg::ADDR_W-1:0]   o_rd_addr,
    input  wire logic [dfr_pkg::BYTE_W-1:0]   i_rd_data
);

    dfr_pkg::t_state r_state, n_state;
    logic [dfr_pkg::CNT_W-1:0]  r_fill, n_fill;
    logic [dfr_pkg::CNT_W-1:0]  r_len, n_len;
    logic [dfr_pkg::ADDR_W-1:0] r_idx, n_idx;

    logic in_acc;
    logic is_delim;
    logic overflow;
    logic is_last;

    assign o_in_ready = (r_state == dfr_pkg::ST_WAIT) || (r_state == dfr_pkg::ST_RECV);
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_delim   = (i_in_byte == i_delimiter);
    // limit in force is the smaller of capacity and store depth
    assign overflow   = (r_fill >= i_capacity) ||
                        (r_fill >= dfr_pkg::CNT_W'(dfr_pkg::STORE_DEPTH));
    assign is_last    = ((dfr_pkg::CNT_W'(r_idx) + dfr_pkg::CNT_W'(1)) == r_len);

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_len   = r_len;
        n_idx   = r_idx;
        o_wr_en = 1'b0;
        o_rd_en = 1'b0;
        unique case (r_state) inside
            dfr_pkg::ST_WAIT, dfr_pkg::ST_RECV: begin
                if (in_acc) begin
                    if (!is_delim) begin
                        if (overflow) begin
                            n_fill  = '0;
                            n_state = dfr_pkg::ST_ERR;
                        end else begin
                            o_wr_en = 1'b1;
                            n_fill  = r_fill + dfr_pkg::CNT_W'(1);
                            n_state = dfr_pkg::ST_RECV;
                        end
                    end else if (r_state == dfr_pkg::ST_RECV) begin
                        if (r_fill == '0) begin
                            n_state = dfr_pkg::ST_WAIT;
                        end else begin
                            n_len   = r_fill;
                            n_fill  = '0;
                            n_idx   = '0;
                            n_state = dfr_pkg::ST_READ;
                        end
                    end
                end
            end
            dfr_pkg::ST_READ: begin
                o_rd_en = 1'b1;
                n_state = dfr_pkg::ST_SHOW;
            end
            dfr_pkg::ST_SHOW: begin
                if (i_out_ready) begin
                    if (is_last) begin
                        n_state = dfr_pkg::ST_WAIT;
                    end else begin
                        n_idx   = r_idx + dfr_pkg::ADDR_W'(1);
                        n_state = dfr_pkg::ST_READ;
                    end
                end
            end
            dfr_pkg::ST_ERR: begin
                if (i_out_ready) begin
                    n_state = dfr_pkg::ST_WAIT;
                end
            end
            default: begin
                n_state = dfr_pkg::ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dfr_pkg::ST_WAIT;
            r_fill  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    assign o_wr_addr = r_fill[dfr_pkg::ADDR_W-1:0];
    assign o_wr_data = i_in_byte;
    assign o_rd_addr = r_idx;

    // RAM read register doubles as the payload output register
    assign o_out_valid   = (r_state == dfr_pkg::ST_SHOW) || (r_state == dfr_pkg::ST_ERR);
    assign o_out_kind    = (r_state == dfr_pkg::ST_ERR) ? dfr_pkg::KIND_ERROR
                                                        : dfr_pkg::KIND_PAYLOAD;
    assign o_out_payload = (r_state == dfr_pkg::ST_ERR) ? '0 : i_rd_data;
    assign o_out_length  = (r_state == dfr_pkg::ST_ERR) ? '0 : r_len;
    assign o_out_last    = (r_state == dfr_pkg::ST_ERR) || is_last;

endmodule
`default_nettype wire

// ===== tb/dfr_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_frame_checker: result checker for the delimiter frame receiver
// Watches the register port and both streams, tracks the frame in progress,
// queues the beats each accepted byte must produce, and compares every result
// beat field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module dfr_frame_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [dfr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dfr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic                              i_s_tvalid,
    input  wire logic                              i_s_tready,
    input  wire logic [dfr_pkg::BYTE_W-1:0]        i_s_tdata,   // [7:0] rx_byte
    input  wire logic                              i_m_tvalid,
    input  wire logic                              i_m_tready,
    input  wire logic [dfr_pkg::OUT_DATA_W-1:0]    i_m_tdata,   // [7:0] payload,
                                                                // [14:8] frame_length
    input  wire logic                              i_m_tuser,   // [0] kind
    input  wire logic                              i_m_tlast,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import dfr_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload;
        logic [CNT_W-1:0]  frame_length;
        logic              last;
    } frame_beat_t;

    frame_beat_t       expected_beats [$];

    // shadow of the receiver
    logic [BYTE_W-1:0] delim_value;
    logic [CNT_W-1:0]  cap_value;
    logic              in_frame;
    logic [CNT_W-1:0]  held;
    logic [BYTE_W-1:0] frame_buf [STORE_DEPTH];

    int                fail_total = 0;

    assign o_fail_count = fail_total;

    initial o_pending = 0;

    task automatic log_failure(input string what, input frame_beat_t want,
                               input frame_beat_t got);
        fail_total++;
        if (fail_total <= 10)
            $display("%0t ns: mismatch (%s): expected kind=%0d payload=%02h len=%0d last=%0d,",
                     $realtime, what, want.kind, want.payload, want.frame_length, want.last,
                     " got kind=%0d payload=%02h len=%0d last=%0d",
                     got.kind, got.payload, got.frame_length, got.last);
    endtask

    task automatic take_byte(input logic [BYTE_W-1:0] b);
        int          lim;
        frame_beat_t beat;
        lim = (cap_value > STORE_DEPTH) ? STORE_DEPTH : int'(cap_value);
        if (held >= lim || held >= STORE_DEPTH) begin
            // overflow: frame dropped, one error beat
            in_frame          = 1'b0;
            held              = '0;
            beat.kind         = KIND_ERROR;
            beat.payload      = '0;
            beat.frame_length = '0;
            beat.last         = 1'b1;
            expected_beats.push_back(beat);
        end else begin
            frame_buf[held] = b;
            held            = held + 1'b1;
        end
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        frame_beat_t beat;
        int          n;
        if (!in_frame) begin
            if (b != delim_value) begin
                in_frame = 1'b1;
                take_byte(b);
            end
        end else if (b != delim_value) begin
            take_byte(b);
        end else begin
            in_frame = 1'b0;
            n        = (held > STORE_DEPTH) ? STORE_DEPTH : int'(held);
            for (int k = 0; k < n; k++) begin
                beat.kind         = KIND_PAYLOAD;
                beat.payload      = frame_buf[k];
                beat.frame_length = n[CNT_W-1:0];
                beat.last         = (k + 1 == n);
                expected_beats.push_back(beat);
            end
            held = '0;
        end
    endtask

    always @(posedge i_clk) begin
        frame_beat_t seen_beat;
        frame_beat_t want_beat;
        string       bad;
        if (!i_rst_n) begin
            delim_value = RESET_DELIMITER;
            cap_value   = RESET_CAPACITY;
            in_frame    = 1'b0;
            held        = '0;
            expected_beats.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_DELIMITER)
                    delim_value = i_cfg_wdata;
                else if (i_cfg_index == REG_CAPACITY)
                    cap_value = i_cfg_wdata[CNT_W-1:0];
            end
            if (i_m_tvalid && i_m_tready) begin
                seen_beat.kind         = i_m_tuser;
                seen_beat.payload      = i_m_tdata[7:0];
                seen_beat.frame_length = i_m_tdata[14:8];
                seen_beat.last         = i_m_tlast;
                if (expected_beats.size() == 0) begin
                    want_beat = '0;
                    log_failure("no beat expected", want_beat, seen_beat);
                end else begin
                    want_beat = expected_beats.pop_front();
                    bad = "";
                    if (seen_beat.kind !== want_beat.kind)
                        bad = {bad, " kind"};
                    if (seen_beat.payload !== want_beat.payload)
                        bad = {bad, " payload"};
                    if (seen_beat.frame_length !== want_beat.frame_length)
                        bad = {bad, " frame_length"};
                    if (seen_beat.last !== want_beat.last)
                        bad = {bad, " last"};
                    if (bad != "")
                        log_failure(bad, want_beat, seen_beat);
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_byte(i_s_tdata);
            o_pending <= expected_beats.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for delimiter_frame_receiver_unit
// Directed frames for the corner cases, then randomized framed traffic and
// noise under several delimiter/capacity settings, with random gaps on the
// input and random back-pressure on the output. Checking is in the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import dfr_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;    // [7:0] rx_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;    // [7:0] payload, [14:8] frame_length
    logic                  m_axis_tuser;    // [0] kind
    logic                  m_axis_tlast;

    int                    fail_count;
    int                    pending_beats;

    // stimulus-side view of the current settings
    logic [BYTE_W-1:0]     cur_delim = RESET_DELIMITER;
    logic [CNT_W-1:0]      cur_cap   = RESET_CAPACITY;
    bit                    send_steady = 1'b0;
    int                    bytes_sent  = 0;

    // output back-pressure state
    int                    stall_left = 0;
    int                    mode_left  = 0;
    bit                    rx_steady  = 1'b0;

    delimiter_frame_receiver_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    dfr_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(60_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    // output side: steady stretches mixed with random stalls, mostly short
    always @(posedge i_clk) begin
        int r;
        if (mode_left == 0) begin
            rx_steady = ($urandom_range(3, 0) == 0);
            mode_left = $urandom_range(300, 50);
        end else begin
            mode_left--;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!rx_steady && $urandom_range(99, 0) < 20) begin
            r          = $urandom_range(99, 0);
            stall_left = (r < 85) ? $urandom_range(3, 1) : $urandom_range(50, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        if (send_steady)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 10);
    endfunction

    function automatic logic [BYTE_W-1:0] other_byte();
        logic [BYTE_W-1:0] v;
        do
            v = BYTE_W'($urandom_range(255, 0));
        while (v == cur_delim);
        return v;
    endfunction

    // tvalid stays high across back-to-back beats; it only drops for a gap
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    // stop input, let every expected beat drain, then let the block settle
    // after a byte that produced no result
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_DELIMITER)
            cur_delim = val;
        else
            cur_cap = val[CNT_W-1:0];
    endtask

    function automatic int frame_len();
        int lim;
        int r;
        lim = (cur_cap > STORE_DEPTH) ? STORE_DEPTH : int'(cur_cap);
        r   = $urandom_range(99, 0);
        if (r < 70)
            return $urandom_range(6, 1);
        else if (r < 90)
            return $urandom_range(20, 7);
        else
            return $urandom_range(lim + 2, (lim > 0) ? lim - 1 : 0);
    endfunction

    task automatic send_frame(input int len, input bit closed);
        send_byte(cur_delim);
        for (int k = 0; k < len; k++)
            send_byte(other_byte());
        if (closed)
            send_byte(cur_delim);
    endtask

    initial begin
        int phase_end;
        int r;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_DELIMITER;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, extremes of the byte, idle delimiters
        send_steady = 1'b1;
        send_byte(RESET_DELIMITER);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(RESET_DELIMITER);
        send_byte(RESET_DELIMITER);
        send_byte(8'h5A);
        send_byte(RESET_DELIMITER);
        // capacity of one: second byte overflows, then a one-byte frame
        write_reg(REG_CAPACITY, 8'd1);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(RESET_DELIMITER);
        // capacity zero: any non-delimiter byte is an error, block stays idle
        write_reg(REG_CAPACITY, 8'd0);
        send_byte(8'h44);
        send_byte(RESET_DELIMITER);
        // capacity lowered below the fill mid-frame
        write_reg(REG_CAPACITY, 8'd64);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        write_reg(REG_CAPACITY, 8'd2);
        send_byte(8'h04);
        send_byte(8'h05);
        send_byte(8'h06);
        send_byte(RESET_DELIMITER);
        // delimiter changed mid-frame; the old one becomes plain data
        write_reg(REG_CAPACITY, 8'd64);
        send_byte(8'h07);
        write_reg(REG_DELIMITER, 8'h07);
        send_byte(RESET_DELIMITER);
        send_byte(8'h07);
        send_steady = 1'b0;

        // random phases over several settings
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin write_reg(REG_DELIMITER, 8'd35); write_reg(REG_CAPACITY, 8'd64); end
                1: begin write_reg(REG_DELIMITER, 8'h00); write_reg(REG_CAPACITY, 8'd1);  end
                2: begin write_reg(REG_DELIMITER, 8'hFF); write_reg(REG_CAPACITY, 8'd8);  end
                3: begin
                    write_reg(REG_DELIMITER, CFG_DATA_W'($urandom_range(255, 0)));
                    write_reg(REG_CAPACITY, 8'd127);
                end
                4: begin
                    write_reg(REG_DELIMITER, CFG_DATA_W'($urandom_range(255, 0)));
                    write_reg(REG_CAPACITY, 8'd0);
                end
                5: begin
                    write_reg(REG_DELIMITER, CFG_DATA_W'($urandom_range(255, 0)));
                    write_reg(REG_CAPACITY, CFG_DATA_W'($urandom_range(64, 1)));
                end
                default: begin
                    // upper bit is dropped: capacity 127, limit is the store depth
                    write_reg(REG_DELIMITER, 8'd35);
                    write_reg(REG_CAPACITY, 8'hFF);
                end
            endcase
            phase_end = bytes_sent + ((ph == 4) ? 15 : 42);
            while (bytes_sent < phase_end) begin
                if ($urandom_range(4, 0) == 0)
                    send_steady = ~send_steady;
                r = $urandom_range(99, 0);
                if (r < 75) begin
                    send_frame(frame_len(), 1'b1);
                end else if (r < 90) begin
                    repeat ($urandom_range(6, 1))
                        send_byte(($urandom_range(3, 0) == 0) ? cur_delim : other_byte());
                end else begin
                    // broken frame: left open, the next delimiter closes it
                    send_frame(frame_len(), 1'b0);
                end
            end
        end

        quiesce();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_beats == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
